// ----- design/mpc_pkg.sv -----
// Shared types and constants of the MAC pair packet counter and blocker.
`default_nettype none

package mpc_pkg;

	localparam int MAC_W             = 48;
	localparam int COUNT_W           = 16;
	localparam int TABLE_ENTRIES_DEF = 64;

	localparam logic [COUNT_W-1:0] COUNT_MAX       = '1;
	localparam logic [COUNT_W-1:0] COUNT_ONE       = COUNT_W'(1);
	localparam logic [COUNT_W-1:0] THRESHOLD_RESET = COUNT_W'(100);

	typedef enum logic [1:0] {
		OP_PACKET       = 2'd0,
		OP_QUERY        = 2'd1,
		OP_RESET_COUNTS = 2'd2,
		OP_CLEAR_TABLE  = 2'd3
	} op_t;

	// Broadcast from the controller to every cell.
	typedef struct packed {
		logic               sample;
		logic               commit;
		op_t                op;
		logic               hit_any;
		logic [MAC_W-1:0]   src;
		logic [MAC_W-1:0]   dst;
		logic [COUNT_W-1:0] threshold;
	} cell_ctl_t;

	// Report of one cell; blocked and count are zero unless the cell matched.
	typedef struct packed {
		logic               is_match;
		logic               is_free;
		logic               blocked;
		logic [COUNT_W-1:0] count;
	} cell_rpt_t;

endpackage

`default_nettype wire

// ----- design/mpc_item_if.sv -----
// Input channel carrying one operation item.
`default_nettype none

interface mpc_item_if
	import mpc_pkg::*;
;
	logic             valid;
	logic             ready;
	op_t              op;
	logic [MAC_W-1:0] src_mac;
	logic [MAC_W-1:0] dst_mac;

	modport source (output valid, output op, output src_mac, output dst_mac, input ready);
	modport sink   (input valid, input op, input src_mac, input dst_mac, output ready);
endinterface

`default_nettype wire

// ----- design/mpc_result_if.sv -----
// Output channel carrying one result item.
`default_nettype none

interface mpc_result_if
	import mpc_pkg::*;
;
	logic               valid;
	logic               ready;
	logic               hit;
	logic               is_blocked;
	logic               newly_blocked;
	logic [COUNT_W-1:0] pair_count;
	logic               table_full;

	modport source (output valid, output hit, output is_blocked, output newly_blocked,
		output pair_count, output table_full, input ready);
	modport sink   (input valid, input hit, input is_blocked, input newly_blocked,
		input pair_count, input table_full, output ready);
endinterface

`default_nettype wire

// ----- design/mpc_cell.sv -----
// One table entry: stored pair, count and blocked mark with its own compare and update.
`default_nettype none

module mpc_cell
	import mpc_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire cell_ctl_t ctl,
	input  wire logic      prev_valid,
	output logic           valid,
	output cell_rpt_t      rpt
);

	logic               valid_q;
	logic [MAC_W-1:0]   src_q;
	logic [MAC_W-1:0]   dst_q;
	logic [COUNT_W-1:0] count_q;
	logic               blocked_q;
	logic               match_s1;
	logic               free_s1;
	logic [COUNT_W-1:0] cnt_inc;
	logic               do_bump;
	logic               do_alloc;

	assign cnt_inc  = (count_q == COUNT_MAX) ? count_q : count_q + COUNT_ONE;
	assign do_bump  = ctl.commit && (ctl.op == OP_PACKET) && match_s1 && !blocked_q;
	// Only the first empty cell may take a new pair, and only if nobody matched.
	assign do_alloc = ctl.commit && (ctl.op == OP_PACKET) && free_s1 && !ctl.hit_any;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			match_s1 <= 1'b0;
			free_s1  <= 1'b0;
		end else begin
			if (ctl.sample) begin
				match_s1 <= valid_q && (src_q == ctl.src) && (dst_q == ctl.dst);
				free_s1  <= !valid_q && prev_valid;
			end
			if (do_alloc) begin
				valid_q <= 1'b1;
			end else if (ctl.commit && (ctl.op == OP_CLEAR_TABLE)) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_alloc) begin
			src_q     <= ctl.src;
			dst_q     <= ctl.dst;
			count_q   <= COUNT_ONE;
			blocked_q <= 1'b0;
		end else if (do_bump) begin
			count_q <= cnt_inc;
			if (cnt_inc == ctl.threshold) begin
				blocked_q <= 1'b1;
			end
		end else if (ctl.commit && (ctl.op == OP_RESET_COUNTS) && valid_q) begin
			count_q <= '0;
		end
	end

	assign valid        = valid_q;
	assign rpt.is_match = match_s1;
	assign rpt.is_free  = free_s1;
	assign rpt.blocked  = match_s1 && blocked_q;
	assign rpt.count    = match_s1 ? count_q : '0;

endmodule

`default_nettype wire

// ----- design/mac_pair_packet_counter_blocker_core.sv -----
// Top level of the MAC pair packet counter and blocker: cell row, controller and result register.
`default_nettype none

// The block tracks source/destination MAC pairs in a row of TABLE_ENTRIES cells.
// Items arrive on item_ch (valid/ready); each carries an operation code and a
// pair. A packet item counts the pair, allocating the first empty cell on a miss
// and blocking the pair when its count reaches the threshold. A query item
// reports the pair's state, a reset-counts item zeroes every count and a
// clear-table item empties the row. Every item yields exactly one result item
// on result_ch. The user must write the threshold through cfg_we/cfg_wdata only
// while idle; the block itself does not enforce it. An accepted item is registered,
// then every cell compares its stored pair with the key and registers the outcome
// (phase_s1), then the cells update and the result register is loaded (phase_s2)
// once the result register is empty or being emptied. The block takes no new item
// before the previous one is committed; the next item is accepted in the same
// cycle as the previous one is written. If the receiver stalls with a result
// waiting, a finished compare holds in the cells and item_ch drops ready.
// After reset the table is empty, the threshold is 100 and no result is pending.
module mac_pair_packet_counter_blocker_core
	import mpc_pkg::*;
#(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [COUNT_W-1:0] cfg_wdata,
	mpc_item_if.sink                item_ch,
	mpc_result_if.source            result_ch
);

	// Threshold register.
	logic [COUNT_W-1:0] threshold_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RESET;
		end else if (cfg_we) begin
			threshold_q <= cfg_wdata;
		end
	end

	// Item held while the cells compare and then update.
	op_t              op_q;
	logic [MAC_W-1:0] src_q;
	logic [MAC_W-1:0] dst_q;
	logic             phase_s1;
	logic             phase_s2;
	logic             out_valid_q;
	logic             commit;
	logic             accept;

	// The commit may go ahead when the result register is empty or being emptied.
	assign commit        = phase_s2 && (!out_valid_q || result_ch.ready);
	assign item_ch.ready = !phase_s1 && (!phase_s2 || commit);
	assign accept        = item_ch.valid && item_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_s1 <= 1'b0;
			phase_s2 <= 1'b0;
		end else begin
			phase_s1 <= accept;
			if (phase_s1) begin
				phase_s2 <= 1'b1;
			end else if (commit) begin
				phase_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= item_ch.op;
			src_q <= item_ch.src_mac;
			dst_q <= item_ch.dst_mac;
		end
	end

	// The row of cells. Each cell hands its valid mark to the next one, so the
	// first empty cell recognises itself; the valid cells always form a prefix.
	cell_ctl_t               ctl;
	cell_rpt_t               rpt [TABLE_ENTRIES];
	logic [TABLE_ENTRIES:0]  valid_chain;
	logic [TABLE_ENTRIES-1:0] match_vec;
	logic [TABLE_ENTRIES-1:0] free_vec;

	assign valid_chain[0] = 1'b1;

	for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
		mpc_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.prev_valid (valid_chain[i]),
			.valid      (valid_chain[i+1]),
			.rpt        (rpt[i])
		);
		assign match_vec[i] = rpt[i].is_match;
		assign free_vec[i]  = rpt[i].is_free;
	end

	// At most one cell matches, so OR-ing the gated reports selects its entry.
	logic               hit_any;
	logic               free_any;
	logic               blk_r;
	logic [COUNT_W-1:0] cnt_r;

	always_comb begin
		blk_r = 1'b0;
		cnt_r = '0;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			blk_r = blk_r | rpt[i].blocked;
			cnt_r = cnt_r | rpt[i].count;
		end
	end

	assign hit_any  = |match_vec;
	assign free_any = |free_vec;

	assign ctl.sample    = phase_s1;
	assign ctl.commit    = commit;
	assign ctl.op        = op_q;
	assign ctl.hit_any   = hit_any;
	assign ctl.src       = src_q;
	assign ctl.dst       = dst_q;
	assign ctl.threshold = threshold_q;

	// Result of the item being committed; the cells perform the same update.
	logic               res_hit;
	logic               res_blk;
	logic               res_newb;
	logic [COUNT_W-1:0] res_cnt;
	logic               res_full;
	logic [COUNT_W-1:0] cnt_inc;

	assign cnt_inc = (cnt_r == COUNT_MAX) ? cnt_r : cnt_r + COUNT_ONE;

	always_comb begin
		res_hit  = 1'b0;
		res_blk  = 1'b0;
		res_newb = 1'b0;
		res_cnt  = '0;
		res_full = 1'b0;
		unique case (op_q)
			OP_PACKET: begin
				if (hit_any) begin
					res_hit = 1'b1;
					if (blk_r) begin
						// A blocked pair is left exactly as it is.
						res_blk = 1'b1;
						res_cnt = cnt_r;
					end else begin
						res_newb = (cnt_inc == threshold_q);
						res_blk  = res_newb;
						res_cnt  = cnt_inc;
					end
				end else if (free_any) begin
					res_cnt = COUNT_ONE;
				end else begin
					res_full = 1'b1;
				end
			end
			OP_QUERY: begin
				res_hit = hit_any;
				res_blk = blk_r;
				res_cnt = cnt_r;
			end
			OP_RESET_COUNTS, OP_CLEAR_TABLE: begin
			end
			default: begin
			end
		endcase
	end

	// Result register.
	logic               hit_q;
	logic               blk_q;
	logic               newb_q;
	logic [COUNT_W-1:0] cnt_q;
	logic               full_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (result_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			hit_q  <= res_hit;
			blk_q  <= res_blk;
			newb_q <= res_newb;
			cnt_q  <= res_cnt;
			full_q <= res_full;
		end
	end

	assign result_ch.valid         = out_valid_q;
	assign result_ch.hit           = hit_q;
	assign result_ch.is_blocked    = blk_q;
	assign result_ch.newly_blocked = newb_q;
	assign result_ch.pair_count    = cnt_q;
	assign result_ch.table_full    = full_q;

`ifndef SYNTHESIS
	// Valid cells always form a prefix of the row.
	a_valid_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({1'b0, valid_chain[TABLE_ENTRIES:1]} + {{TABLE_ENTRIES{1'b0}}, 1'b1}))
		else $error("valid cells do not form a prefix");

	// A pair is held in at most one cell, and only one cell claims to be first free.
	a_single_match: assert property (@(posedge clk) disable iff (!arst_n)
		phase_s2 |-> $onehot0(match_vec) && $onehot0(free_vec))
		else $error("more than one cell matched or claimed to be free");

	// A committed item shows up as a pending result in the next cycle.
	a_commit_result: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> out_valid_q)
		else $error("committed item did not produce a result");

	// A full-table result carries nothing else.
	a_full_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && full_q |-> !hit_q && !blk_q && !newb_q && (cnt_q == '0))
		else $error("table full result has other fields set");
`endif

endmodule

`default_nettype wire
